// ===== hw/rtl/smbs_pkg.sv =====
// ----------------------------------------------------------------------------
// smbs_pkg
// Shared widths and codes of the sorted matrix search unit.
// ----------------------------------------------------------------------------
package smbs_pkg;

    // item field widths
    localparam int VAL_W = 32;
    localparam int IDX_W = 4;

    // configuration port
    localparam int CFG_W     = 5;
    localparam int CFG_IDX_W = 1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_IN_USE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS_IN_USE = 1'b1;

    // item operation codes
    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

endpackage

// ===== hw/rtl/smbs_mem.sv =====
// ----------------------------------------------------------------------------
// smbs_mem
// Matrix store: one write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module smbs_mem #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic [AW-1:0]                    i_waddr,
    input  logic signed [smbs_pkg::VAL_W-1:0] i_wdata,
    input  logic                             i_re,
    input  logic [AW-1:0]                    i_raddr,
    output logic signed [smbs_pkg::VAL_W-1:0] o_rdata
);

    logic signed [smbs_pkg::VAL_W-1:0] mem [DEPTH];
    logic signed [smbs_pkg::VAL_W-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // read port, read data registered
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/smbs_seq.sv =====
// ----------------------------------------------------------------------------
// smbs_seq
// Search sequencer: binary search over rows, then within the bracketing row.
// ----------------------------------------------------------------------------
module smbs_seq #(
    parameter int MAX_ROWS = 16,
    parameter int MAX_COLS = 16,
    parameter int AW       = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_search,
    input  logic signed [smbs_pkg::VAL_W-1:0] i_target,
    input  logic [$clog2(MAX_ROWS+1)-1:0]     i_nrows,
    input  logic [$clog2(MAX_COLS+1)-1:0]     i_ncols,
    output logic                              o_busy,
    output logic                              o_rd_en,
    output logic [AW-1:0]                     o_rd_addr,
    input  logic signed [smbs_pkg::VAL_W-1:0] i_rd_data,
    output logic                              o_valid,
    output logic                              o_found
);

    localparam int RW  = $clog2(MAX_ROWS + 1);
    localparam int CWD = $clog2(MAX_COLS + 1);
    localparam int SW  = (RW > CWD) ? RW : CWD;
    localparam int RIW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CIW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

    // sequencer states
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_RMID   = 3'd1;
    localparam logic [2:0] S_RFIRST = 3'd2;
    localparam logic [2:0] S_RLAST  = 3'd3;
    localparam logic [2:0] S_CMID   = 3'd4;
    localparam logic [2:0] S_CCMP   = 3'd5;

    logic [2:0]                        r_state, n_state;
    logic [SW-1:0]                     r_lo, n_lo;
    logic [SW-1:0]                     r_hi, n_hi;      // exclusive bound
    logic [SW-1:0]                     r_mid, n_mid;
    logic [RIW-1:0]                    r_row, n_row;
    logic signed [smbs_pkg::VAL_W-1:0] r_first, n_first;
    logic signed [smbs_pkg::VAL_W-1:0] r_target, n_target;
    logic                              r_valid, n_valid;
    logic                              r_found, n_found;

    logic [SW-1:0]  w_span;
    logic [SW-1:0]  w_mid;
    logic [RIW-1:0] w_rd_row;
    logic [CIW-1:0] w_rd_col;

    // midpoint of the half-open range, valid when lo < hi
    assign w_span = r_hi - r_lo - SW'(1);
    assign w_mid  = r_lo + (w_span >> 1);

    // next-state logic
    always_comb begin
        n_state  = r_state;
        n_lo     = r_lo;
        n_hi     = r_hi;
        n_mid    = r_mid;
        n_row    = r_row;
        n_first  = r_first;
        n_target = r_target;
        n_valid  = 1'b0;
        n_found  = r_found;
        o_rd_en  = 1'b0;
        w_rd_row = r_row;
        w_rd_col = '0;
        case (r_state)
            S_IDLE: begin
                if (i_search) begin
                    n_target = i_target;
                    if (i_nrows == '0 || i_ncols == '0) begin
                        n_valid = 1'b1;
                        n_found = 1'b0;
                    end else begin
                        n_lo    = '0;
                        n_hi    = SW'(i_nrows);
                        n_state = S_RMID;
                    end
                end
            end
            S_RMID: begin
                if (r_lo >= r_hi) begin
                    n_valid = 1'b1;
                    n_found = 1'b0;
                    n_state = S_IDLE;
                end else begin
                    n_mid    = w_mid;
                    o_rd_en  = 1'b1;
                    w_rd_row = RIW'(w_mid);
                    w_rd_col = '0;
                    n_state  = S_RFIRST;
                end
            end
            S_RFIRST: begin
                // first entry arrives, fetch the last one
                n_first  = i_rd_data;
                o_rd_en  = 1'b1;
                w_rd_row = RIW'(r_mid);
                w_rd_col = CIW'(i_ncols - CWD'(1));
                n_state  = S_RLAST;
            end
            S_RLAST: begin
                if (r_target >= r_first && r_target <= i_rd_data) begin
                    n_row   = RIW'(r_mid);
                    n_lo    = '0;
                    n_hi    = SW'(i_ncols);
                    n_state = S_CMID;
                end else begin
                    if (r_target > i_rd_data) begin
                        n_lo = r_mid + SW'(1);
                    end else begin
                        n_hi = r_mid;
                    end
                    n_state = S_RMID;
                end
            end
            S_CMID: begin
                if (r_lo >= r_hi) begin
                    n_valid = 1'b1;
                    n_found = 1'b0;
                    n_state = S_IDLE;
                end else begin
                    n_mid    = w_mid;
                    o_rd_en  = 1'b1;
                    w_rd_row = r_row;
                    w_rd_col = CIW'(w_mid);
                    n_state  = S_CCMP;
                end
            end
            S_CCMP: begin
                if (i_rd_data == r_target) begin
                    n_valid = 1'b1;
                    n_found = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    if (i_rd_data < r_target) begin
                        n_lo = r_mid + SW'(1);
                    end else begin
                        n_hi = r_mid;
                    end
                    n_state = S_CMID;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // row-major read address
    assign o_rd_addr = AW'(w_rd_row) * AW'(MAX_COLS) + AW'(w_rd_col);

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_lo     <= n_lo;
        r_hi     <= n_hi;
        r_mid    <= n_mid;
        r_row    <= n_row;
        r_first  <= n_first;
        r_target <= n_target;
        r_found  <= n_found;
    end

    assign o_busy  = (r_state != S_IDLE);
    assign o_valid = r_valid;
    assign o_found = r_found;

    // memory reads only while a search runs
    a_read_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rd_en |-> (r_state != S_IDLE))
        else $error("memory read issued while idle");

    // every data-consuming state follows an issued read
    a_read_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RFIRST || r_state == S_RLAST || r_state == S_CCMP)
        |-> $past(o_rd_en))
        else $error("read data consumed without a read");

    // search range never inverts
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (r_lo <= r_hi))
        else $error("search range inverted");

    // a hit can only come from the column compare
    a_hit_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_found) |-> ($past(r_state) == S_CCMP))
        else $error("found reported outside column compare");

endmodule

// ===== hw/rtl/sorted_matrix_binary_search_unit.sv =====
// ----------------------------------------------------------------------------
// sorted_matrix_binary_search_unit
// Matrix store with a two-level binary search for a target value.
// ----------------------------------------------------------------------------
// A write item (op = 0) stores one entry and gives no result; busy stays
// low, so the next item may follow at once. A search item (op = 1) holds
// busy while the sequencer walks the single read port of the matrix store:
// each row probe is the midpoint and first-entry read, the last-entry read
// and a compare, each column probe is a read and a compare, and a search
// ends with not found once the range is empty. With zero rows or zero
// columns in use the result comes in the cycle after accept. The o_valid
// strobe is high for exactly one cycle, with the outcome on o_found, and
// cannot be held off; the next item may be started in that same cycle.
// Entries read by a search must have been written since reset.
module sorted_matrix_binary_search_unit #(
    parameter int MAX_ROWS = 16,
    parameter int MAX_COLS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // item channel
    input  logic                                 start,
    output logic                                 busy,
    input  logic                                 i_op,
    input  logic [smbs_pkg::IDX_W-1:0]           i_row_index,
    input  logic [smbs_pkg::IDX_W-1:0]           i_col_index,
    input  logic signed [smbs_pkg::VAL_W-1:0]    i_value,
    // result
    output logic                                 o_valid,
    output logic                                 o_found,
    // configuration
    input  logic                                 i_cfg_we,
    input  logic [smbs_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [smbs_pkg::CFG_W-1:0]           i_cfg_wdata
);

    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int RW    = $clog2(MAX_ROWS + 1);
    localparam int CWD   = $clog2(MAX_COLS + 1);
    localparam int RCMPW = (RW > smbs_pkg::CFG_W) ? RW : smbs_pkg::CFG_W;
    localparam int CCMPW = (CWD > smbs_pkg::CFG_W) ? CWD : smbs_pkg::CFG_W;

    logic [smbs_pkg::CFG_W-1:0]        r_rows_in_use;
    logic [smbs_pkg::CFG_W-1:0]        r_cols_in_use;
    logic [RW-1:0]                     w_nrows;
    logic [CWD-1:0]                    w_ncols;
    logic                              w_accept;
    logic                              w_we;
    logic [AW-1:0]                     w_waddr;
    logic                              w_rd_en;
    logic [AW-1:0]                     w_rd_addr;
    logic signed [smbs_pkg::VAL_W-1:0] w_rd_data;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_in_use <= '0;
            r_cols_in_use <= smbs_pkg::CFG_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                smbs_pkg::CFG_ROWS_IN_USE: r_rows_in_use <= i_cfg_wdata;
                smbs_pkg::CFG_COLS_IN_USE: r_cols_in_use <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // clamp the in-use sizes to the store capacity
    assign w_nrows = (RCMPW'(r_rows_in_use) > RCMPW'(MAX_ROWS)) ?
                     RW'(MAX_ROWS) : RW'(r_rows_in_use);
    assign w_ncols = (CCMPW'(r_cols_in_use) > CCMPW'(MAX_COLS)) ?
                     CWD'(MAX_COLS) : CWD'(r_cols_in_use);

    // item accept and write decode; out-of-range writes are dropped
    assign w_accept = start && !busy;
    assign w_we     = w_accept && (i_op == smbs_pkg::OP_WRITE) &&
                      (32'(i_row_index) < MAX_ROWS) && (32'(i_col_index) < MAX_COLS);
    assign w_waddr  = AW'(i_row_index) * AW'(MAX_COLS) + AW'(i_col_index);

    smbs_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (i_value),
        .i_re    (w_rd_en),
        .i_raddr (w_rd_addr),
        .o_rdata (w_rd_data)
    );

    smbs_seq #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS),
        .AW       (AW)
    ) u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_search  (w_accept && (i_op == smbs_pkg::OP_SEARCH)),
        .i_target  (i_value),
        .i_nrows   (w_nrows),
        .i_ncols   (w_ncols),
        .o_busy    (busy),
        .o_rd_en   (w_rd_en),
        .o_rd_addr (w_rd_addr),
        .i_rd_data (w_rd_data),
        .o_valid   (o_valid),
        .o_found   (o_found)
    );

endmodule
